@@ src/assert_macros.svh @@
// Assertion macros for the checker file of the quaternion integrator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QAI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qai check failed");

// Next-cycle implication, disabled during reset.
`define QAI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qai check failed");

// Next-cycle implication that also holds through reset.
`define QAI_ASSERT_NXT_ALL(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qai check failed");

`endif

@@ src/qai_pkg.sv @@
// Package with item types, constants and tables of the quaternion integrator.
`default_nettype none
package qai_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;

  localparam logic [15:0] PERIOD_RESET = 16'd655;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  localparam logic [63:0] SMALL_NM2 = 64'd180143985;
  localparam logic [63:0] DEGEN_N2 = 64'd1152921504606;
  localparam logic signed [34:0] TWO_PI_Q29 = 35'sd3373259426;
  localparam logic signed [34:0] PI_Q29 = 35'sd1686629713;
  localparam logic signed [34:0] HALF_PI_Q29 = 35'sd843314857;
  localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;

  // Reciprocal of three in Q33, rounded up, exact for dividends below 2^32.
  localparam logic [33:0] RECIP3_Q33 = 34'h0_AAAA_AAAB;

  localparam logic [28:0] ATAN_Q29 [32] = '{
    29'd421657428, 29'd248918915, 29'd131521918, 29'd66762579, 29'd33510843,
    29'd16771758, 29'd8387925, 29'd4194219, 29'd2097141, 29'd1048575,
    29'd524288, 29'd262144, 29'd131072, 29'd65536, 29'd32768, 29'd16384,
    29'd8192, 29'd4096, 29'd2048, 29'd1024, 29'd512, 29'd256, 29'd128,
    29'd64, 29'd32, 29'd16, 29'd8, 29'd4, 29'd2, 29'd1, 29'd1, 29'd0
  };

  // Hamilton product terms, four per output component.
  localparam logic [1:0] TERM_A [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2
  };
  localparam logic [1:0] TERM_D [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
    2'd2, 2'd0, 2'd1, 2'd3, 2'd3, 2'd0, 2'd2, 2'd1
  };
  localparam logic TERM_NEG [16] = '{
    1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1
  };

  typedef enum logic {
    OP_INTEGRATE = 1'b0,
    OP_LOAD      = 1'b1
  } opcode_t;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [31:0] load_w;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] att_w;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;
    logic               reset_to_identity;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage
`default_nettype wire

@@ src/qai_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none
module qai_mul (
  input  wire logic               clk,
  input  wire logic signed [33:0] a,
  input  wire logic signed [33:0] b,
  output logic signed [67:0]      p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

@@ src/qai_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module qai_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [31:0] den,
  output logic [63:0]      quo,
  output logic             done
);
  logic [31:0] rem;
  logic [31:0] dreg;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] sh;
  logic        ge;

  assign sh = {rem, quo[63]};
  assign ge = sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
        rem  <= '0;
        quo  <= num;
        dreg <= den;
      end else if (busy) begin
        rem  <= ge ? 32'(sh - {1'b0, dreg}) : sh[31:0];
        quo  <= {quo[62:0], ge};
        cnt  <= cnt + 6'd1;
        busy <= (cnt != 6'd63);
        done <= (cnt == 6'd63);
      end else begin
        done <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ src/qai_sqrt.sv @@
// Integer square root, two radicand bits per cycle.
`default_nettype none
module qai_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire qai_pkg::unit_ctl_t ctl_in,
  input  wire logic [63:0] x,
  output logic [31:0]      root,
  output qai_pkg::unit_ctl_t ctl_out
);
  import qai_pkg::*;

  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bm;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = r + bm;
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      ctl_out <= '0;
      cnt     <= '0;
    end else begin
      if (ctl_in.start) begin
        busy          <= 1'b1;
        ctl_out.start <= 1'b1;
        ctl_out.done  <= 1'b0;
        cnt           <= '0;
        v             <= x;
        r             <= '0;
        bm            <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (v >= trial) begin
          v <= v - trial;
          r <= (r >> 1) + bm;
        end else begin
          r <= r >> 1;
        end
        bm            <= bm >> 2;
        cnt           <= cnt + 5'd1;
        busy          <= (cnt != 5'd31);
        ctl_out.start <= (cnt != 5'd31);
        ctl_out.done  <= (cnt == 5'd31);
      end else begin
        ctl_out.done <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ src/quaternion_attitude_integrator.sv @@
// Top level of the gyro quaternion attitude integrator.
//
// A load item stores the quaternion and gives its result through S_FIN and the
// output register. An integrate item takes the small-angle path or the
// large-angle path, and is shorter when the product norm is degenerate; its
// duration is set by the restoring divider, used three times for the axis
// terms on the large-angle path and four times to normalise, with passes through
// the shared multiplier (which also forms the series coefficient by a
// reciprocal multiplication), the square root unit and one CORDIC step per cycle.
// One item is in work at a time; a finished item waits in the output register
// while the next one is accepted.
`default_nettype none
module quaternion_attitude_integrator (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire qai_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output qai_pkg::out_item_t     out_data
);
  import qai_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RV_MUL, S_RV_ACC, S_NM_MUL, S_NM_ACC, S_SM_CMUL, S_SM_COEF,
    S_SM_VMUL, S_SM_VACC, S_SQ_GO, S_SQ_W, S_RED, S_TURN, S_CORD, S_LG_VMUL,
    S_LG_DIVGO, S_LG_DIVW, S_PR_MUL, S_PR_ACC, S_SHIFT, S_N2_MUL, S_N2_ACC,
    S_CHK, S_NQ_GO, S_NQ_W, S_ND_GO, S_ND_W, S_FIX, S_FIN
  } state_t;

  state_t state;
  logic [1:0]         idx;
  logic [3:0]         cnt;
  logic [4:0]         ck;
  logic [15:0]        period;
  logic signed [31:0] att [4];
  logic signed [15:0] rate [3];
  logic signed [31:0] rv [3];
  logic [63:0]        nm2;
  logic [63:0]        n2;
  logic [31:0]        nm;
  logic [31:0]        nrm;
  logic [32:0]        s33;
  logic signed [34:0] tq;
  logic               cneg;
  logic signed [35:0] cx;
  logic signed [35:0] cy;
  logic signed [32:0] dq [4];
  logic signed [35:0] pa [4];
  logic [3:0]         shk;
  logic               flag;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] mul_p;
  logic               div_start;
  logic [63:0]        div_num;
  logic [31:0]        div_den;
  logic [63:0]        div_q;
  logic               div_done;
  unit_ctl_t          sq_req;
  unit_ctl_t          sq_rsp;
  logic [63:0]        sq_x;
  logic [31:0]        sq_r;

  logic [63:0]        nm2_sum;
  logic signed [67:0] prod_rnd;
  logic signed [35:0] term;
  logic [35:0]        pmag [4];
  logic [35:0]        mx;
  logic [3:0]         kk;
  logic signed [34:0] t1;
  logic signed [35:0] xs;
  logic signed [35:0] ys;
  logic [32:0]        sm_mag;
  logic [63:0]        w60;
  logic [63:0]        wq;
  logic [63:0]        s60;
  logic [32:0]        div_q33;
  logic               lg_neg;
  logic [35:0]        nd_mag;
  logic [35:0]        cy_mag;

  function automatic logic [33:0] mag32(input logic signed [31:0] v);
    logic signed [33:0] e;
    e = {{2{v[31]}}, v};
    return e[33] ? 34'(-e) : 34'(e);
  endfunction

  function automatic logic [35:0] mag36(input logic signed [35:0] v);
    return v[35] ? 36'(-v) : 36'(v);
  endfunction

  qai_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  qai_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_q), .done(div_done)
  );

  qai_sqrt u_sqrt (
    .clk(clk), .rst(rst), .ctl_in(sq_req), .x(sq_x), .root(sq_r), .ctl_out(sq_rsp)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign nm2_sum  = nm2 + mul_p[63:0];
  assign prod_rnd = mul_p + 68'sd536870912;
  assign term     = prod_rnd[65:30];
  assign t1       = (tq > PI_Q29) ? 35'(tq - TWO_PI_Q29) : tq;
  assign xs       = cx >>> ck;
  assign ys       = cy >>> ck;
  assign sm_mag   = 33'((mul_p[63:0] + 64'd536870912) >> 30);
  assign w60      = 64'h1000_0000_0000_0000 - {nm2[60:0], 3'b000};
  assign wq       = w60 + 64'd536870912;
  assign s60      = 64'h0800_0000_0000_0000 - {33'b0, mul_p[63:33]} + 64'd67108864;
  assign div_q33  = div_q[32:0];
  assign lg_neg   = cy[35] ^ rv[idx][31];
  assign nd_mag   = mag36(pa[idx]);
  assign cy_mag   = mag36(cy);

  always_comb begin
    mx = '0;
    for (int i = 0; i < 4; i++) begin
      pmag[i] = mag36(pa[i]);
      if (pmag[i] > mx) mx = pmag[i];
    end
    kk = 4'd8;
    for (int s = 8; s >= 0; s--) begin
      if ((mx >> s) < 36'(ONE_Q30)) kk = 4'(s);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_RV_MUL: begin
        mul_a = {{18{rate[idx][15]}}, rate[idx]};
        mul_b = {18'b0, period};
      end
      S_NM_MUL: begin
        mul_a = mag32(rv[idx]);
        mul_b = mag32(rv[idx]);
      end
      S_SM_CMUL: begin
        mul_a = {4'b0, nm2[27:0], 2'b00};
        mul_b = RECIP3_Q33;
      end
      S_SM_VMUL: begin
        mul_a = {1'b0, s33};
        mul_b = mag32(rv[idx]);
      end
      S_LG_VMUL: begin
        mul_a = cy_mag[33:0];
        mul_b = mag32(rv[idx]);
      end
      S_PR_MUL: begin
        mul_a = {{2{att[TERM_A[cnt]][31]}}, att[TERM_A[cnt]]};
        mul_b = {dq[TERM_D[cnt]][32], dq[TERM_D[cnt]]};
      end
      S_N2_MUL: begin
        mul_a = pa[idx][33:0];
        mul_b = pa[idx][33:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    sq_req.start = 1'b0;
    sq_req.done  = 1'b0;
    sq_x         = '0;
    unique case (state)
      S_LG_DIVGO: begin
        div_start = 1'b1;
        div_num   = mul_p[63:0] + {33'b0, nm[31:1]};
        div_den   = nm;
      end
      S_ND_GO: begin
        div_start = 1'b1;
        div_num   = {nd_mag[33:0], 30'b0} + {33'b0, nrm[31:1]};
        div_den   = nrm;
      end
      S_SQ_GO: begin
        sq_req.start = 1'b1;
        sq_x         = nm2;
      end
      S_NQ_GO: begin
        sq_req.start = 1'b1;
        sq_x         = n2;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      period    <= PERIOD_RESET;
      att[0]    <= ONE_Q30;
      att[1]    <= '0;
      att[2]    <= '0;
      att[3]    <= '0;
      idx       <= '0;
      cnt       <= '0;
      ck        <= '0;
      flag      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) period <= cfg_data;
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            flag <= 1'b0;
            idx  <= '0;
            if (in_data.opcode == OP_LOAD) begin
              att[0] <= in_data.load_w;
              att[1] <= in_data.load_x;
              att[2] <= in_data.load_y;
              att[3] <= in_data.load_z;
              state  <= S_FIN;
            end else begin
              rate[0] <= in_data.rate_x;
              rate[1] <= in_data.rate_y;
              rate[2] <= in_data.rate_z;
              state   <= S_RV_MUL;
            end
          end
        end
        S_RV_MUL: state <= S_RV_ACC;
        S_RV_ACC: begin
          rv[idx] <= mul_p[31:0];
          if (idx == 2'd2) begin
            idx   <= '0;
            nm2   <= '0;
            state <= S_NM_MUL;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_RV_MUL;
          end
        end
        S_NM_MUL: state <= S_NM_ACC;
        S_NM_ACC: begin
          nm2 <= nm2_sum;
          if (idx == 2'd2) begin
            idx   <= '0;
            state <= (nm2_sum <= SMALL_NM2) ? S_SM_CMUL : S_SQ_GO;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_NM_MUL;
          end
        end
        S_SM_CMUL: state <= S_SM_COEF;
        S_SM_COEF: begin
          s33   <= s60[59:27];
          dq[0] <= $signed(wq[62:30]);
          state <= S_SM_VMUL;
        end
        S_SM_VMUL: state <= S_SM_VACC;
        S_SM_VACC: begin
          dq[idx + 2'd1] <= rv[idx][31] ? -$signed(sm_mag) : $signed(sm_mag);
          if (idx == 2'd2) begin
            cnt   <= '0;
            pa[0] <= '0;
            pa[1] <= '0;
            pa[2] <= '0;
            pa[3] <= '0;
            state <= S_PR_MUL;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_SM_VMUL;
          end
        end
        S_SQ_GO: state <= S_SQ_W;
        S_SQ_W: begin
          if (sq_rsp.done) begin
            nm    <= sq_r;
            tq    <= {2'b00, sq_r, 1'b0};
            state <= S_RED;
          end
        end
        S_RED: begin
          if (tq >= TWO_PI_Q29) tq <= tq - TWO_PI_Q29;
          else state <= S_TURN;
        end
        S_TURN: begin
          if (t1 > HALF_PI_Q29) begin
            tq   <= PI_Q29 - t1;
            cneg <= 1'b1;
          end else if (t1 < -HALF_PI_Q29) begin
            tq   <= -PI_Q29 - t1;
            cneg <= 1'b1;
          end else begin
            tq   <= t1;
            cneg <= 1'b0;
          end
          cx    <= GAIN_Q30;
          cy    <= '0;
          ck    <= '0;
          state <= S_CORD;
        end
        S_CORD: begin
          if (tq >= 0) begin
            cx <= cx - ys;
            cy <= cy + xs;
            tq <= tq - $signed({6'b0, ATAN_Q29[ck]});
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            tq <= tq + $signed({6'b0, ATAN_Q29[ck]});
          end
          ck <= ck + 5'd1;
          if (ck == 5'(CORDIC_STEPS - 1)) begin
            idx   <= '0;
            state <= S_LG_VMUL;
          end
        end
        S_LG_VMUL: begin
          dq[0] <= cneg ? 33'(-cx) : 33'(cx);
          state <= S_LG_DIVGO;
        end
        S_LG_DIVGO: state <= S_LG_DIVW;
        S_LG_DIVW: begin
          if (div_done) begin
            dq[idx + 2'd1] <= lg_neg ? -$signed(div_q33) : $signed(div_q33);
            if (idx == 2'd2) begin
              cnt   <= '0;
              pa[0] <= '0;
              pa[1] <= '0;
              pa[2] <= '0;
              pa[3] <= '0;
              state <= S_PR_MUL;
            end else begin
              idx   <= idx + 2'd1;
              state <= S_LG_VMUL;
            end
          end
        end
        S_PR_MUL: state <= S_PR_ACC;
        S_PR_ACC: begin
          pa[cnt[3:2]] <= TERM_NEG[cnt] ? pa[cnt[3:2]] - term : pa[cnt[3:2]] + term;
          cnt <= cnt + 4'd1;
          state <= (cnt == 4'd15) ? S_SHIFT : S_PR_MUL;
        end
        S_SHIFT: begin
          for (int i = 0; i < 4; i++) pa[i] <= pa[i] >>> kk;
          shk   <= kk;
          idx   <= '0;
          n2    <= '0;
          state <= S_N2_MUL;
        end
        S_N2_MUL: state <= S_N2_ACC;
        S_N2_ACC: begin
          n2 <= n2 + mul_p[63:0];
          if (idx == 2'd3) begin
            idx   <= '0;
            state <= S_CHK;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_N2_MUL;
          end
        end
        S_CHK: begin
          if (shk == 4'd0 && n2 <= DEGEN_N2) begin
            att[0] <= ONE_Q30;
            att[1] <= '0;
            att[2] <= '0;
            att[3] <= '0;
            flag   <= 1'b1;
            state  <= S_FIN;
          end else begin
            state <= S_NQ_GO;
          end
        end
        S_NQ_GO: state <= S_NQ_W;
        S_NQ_W: begin
          if (sq_rsp.done) begin
            nrm   <= sq_r;
            idx   <= '0;
            state <= S_ND_GO;
          end
        end
        S_ND_GO: state <= S_ND_W;
        S_ND_W: begin
          if (div_done) begin
            pa[idx] <= pa[idx][35] ? -$signed(div_q[35:0]) : $signed(div_q[35:0]);
            if (idx == 2'd3) begin
              state <= S_FIX;
            end else begin
              idx   <= idx + 2'd1;
              state <= S_ND_GO;
            end
          end
        end
        S_FIX: begin
          for (int i = 0; i < 4; i++) begin
            att[i] <= pa[0][35] ? 32'(-pa[i]) : pa[i][31:0];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid                  <= 1'b1;
            out_data.att_w             <= att[0];
            out_data.att_x             <= att[1];
            out_data.att_y             <= att[2];
            out_data.att_z             <= att[3];
            out_data.reset_to_identity <= flag;
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/qai_checker.sv @@
// Port-level checker for the quaternion integrator and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module qai_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire qai_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire qai_pkg::out_item_t out_data
);
  import qai_pkg::*;

  logic in_fire;
  logic ident;

  assign in_fire = in_valid && in_ready && (in_data.opcode == OP_LOAD ||
                                            in_data.opcode == OP_INTEGRATE);
  assign ident = out_data.att_w == ONE_Q30 && out_data.att_x == 0 &&
                 out_data.att_y == 0 && out_data.att_z == 0;

  `QAI_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready)
  `QAI_ASSERT_IMP(a_flag_is_identity, out_valid && out_data.reset_to_identity, ident)
  `QAI_ASSERT_NXT_ALL(a_reset_empties_output, rst, !out_valid)
  `QAI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind quaternion_attitude_integrator qai_checker u_qai_checker (.*);
`default_nettype wire
